// ===== rtl/ptt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ptt_pkg;

	localparam int unsigned RESULT_LIMIT = 16;
	localparam int unsigned RUN_CNT_W = $clog2(RESULT_LIMIT);

	localparam logic [1:0] CMD_SET   = 2'd0;
	localparam logic [1:0] CMD_KILL  = 2'd1;
	localparam logic [1:0] CMD_QUERY = 2'd2;
	localparam logic [1:0] CMD_TICK  = 2'd3;

	localparam logic [1:0] KIND_SET   = 2'd0;
	localparam logic [1:0] KIND_KILL  = 2'd1;
	localparam logic [1:0] KIND_QUERY = 2'd2;
	localparam logic [1:0] KIND_FIRED = 2'd3;

	typedef struct packed {
		logic        valid;
		logic [31:0] key;
		logic [31:0] period;
		logic [31:0] count;
	} ptt_entry_t;

	// broadcast to every cell; at most one of upd, ins, del, tick, shift is set
	typedef struct packed {
		logic        upd;
		logic        ins;
		logic        del;
		logic        tick;
		logic        shift;
		logic [31:0] id;
		logic [31:0] ticks;
	} ptt_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/ptt_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ptt_div import ptt_pkg::*; #(
	parameter int unsigned TICK_MS = 10
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] dividend,
	output logic             done,
	output logic [31:0]      quotient
);

	// x / TICK_MS = (t + ((x - t) >> SH1)) >> SH2, with t = (x * MAGIC) >> 32
	localparam int unsigned LOG_D = $clog2(TICK_MS);
	localparam int unsigned SH1   = (LOG_D > 0) ? 1 : 0;
	localparam int unsigned SH2   = (LOG_D > 0) ? LOG_D - 1 : 0;
	localparam logic [63:0] MAGIC_W =
		(((64'd1 << LOG_D) - 64'(TICK_MS)) << 32) / 64'(TICK_MS) + 64'd1;
	localparam logic [31:0] MAGIC = MAGIC_W[31:0];

	logic [1:0]  cnt_q;
	logic [31:0] x_q;
	logic [31:0] t_q;
	logic [31:0] quo_q;
	logic [63:0] prod;
	logic [31:0] diff;
	logic [31:0] sum;

	assign prod = x_q * MAGIC;
	assign diff = x_q - t_q;
	assign sum  = t_q + (diff >> SH1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 2'd2;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= dividend;
		end
		if (cnt_q == 2'd2) begin
			t_q <= prod[63:32];
		end
		if (cnt_q == 2'd1) begin
			quo_q <= sum >> SH2;
		end
	end

	assign done     = cnt_q == '0;
	assign quotient = quo_q;

endmodule

`default_nettype wire

// ===== rtl/ptt_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ptt_cell import ptt_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire ptt_ctl_t    ctl,
	input  wire ptt_entry_t  left_ent,
	input  wire logic        left_gt,
	input  wire ptt_entry_t  right_ent,
	input  wire logic        right_due,
	input  wire logic [31:0] right_key,
	output ptt_entry_t       ent,
	output logic             gt,
	output logic             match,
	output logic             due,
	output logic [31:0]      due_key
);

	logic        valid_q;
	logic [31:0] key_q;
	logic [31:0] period_q;
	logic [31:0] count_q;
	ptt_entry_t  ent_nxt;
	logic        due_q;
	logic [31:0] due_key_q;

	assign ent   = '{valid: valid_q, key: key_q, period: period_q, count: count_q};
	assign match = valid_q && (key_q == ctl.id);
	assign gt    = !valid_q || (key_q > ctl.id);

	always_comb begin
		ent_nxt = ent;
		if (ctl.upd && match) begin
			ent_nxt.period = ctl.ticks;
			ent_nxt.count  = ctl.ticks;
		end
		if (ctl.ins && gt) begin
			if (left_gt) begin
				ent_nxt = left_ent;
			end else begin
				ent_nxt = '{valid: 1'b1, key: ctl.id, period: ctl.ticks, count: ctl.ticks};
			end
		end
		if (ctl.del && (gt || match)) begin
			ent_nxt = right_ent;
		end
		if (ctl.tick && valid_q) begin
			ent_nxt.count = (count_q <= 32'd1) ? period_q : count_q - 32'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			due_q   <= 1'b0;
		end else begin
			valid_q <= ent_nxt.valid;
			if (ctl.tick) begin
				due_q <= valid_q && (count_q <= 32'd1);
			end else if (ctl.shift) begin
				due_q <= right_due;
			end
		end
	end

	always_ff @(posedge clk) begin
		key_q    <= ent_nxt.key;
		period_q <= ent_nxt.period;
		count_q  <= ent_nxt.count;
		if (ctl.tick) begin
			due_key_q <= key_q;
		end else if (ctl.shift) begin
			due_key_q <= right_key;
		end
	end

	assign due     = due_q;
	assign due_key = due_key_q;

endmodule

`default_nettype wire

// ===== rtl/periodic_timer_table.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel | direction | handshake           | payload
// in      | in        | in_valid, in_stall   | command, timer_id, period_ms
// out     | out       | out_valid, out_stall | reply_kind, reply_id, success, last_of_run
//
// Kill and query need no further state; the reply word is registered at acceptance.
// Set: a reciprocal multiply by 1/TICK_MS (x_q, t_q, quo_q), then the cell row update.
// Tick sets the due marks, which then shift out of the cell row one cell per cycle
// while the output is not stalled, in key order since the row is kept sorted.
// Reset clears all entries at once. A stalled output word holds the block.
module periodic_timer_table import ptt_pkg::*; #(
	parameter int unsigned NUM_TIMERS = 16,
	parameter int unsigned TICK_MS    = 10
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  command,
	input  wire logic [31:0] timer_id,
	input  wire logic [31:0] period_ms,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       reply_kind,
	output logic [31:0]      reply_id,
	output logic             success,
	output logic             last_of_run
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_SCAN = 3'b100
	} state_t;

	state_t                 state_q;
	logic [31:0]            id_q;
	logic [RUN_CNT_W-1:0]   n_q;
	logic                   out_valid_q;
	logic [1:0]             kind_q;
	logic [31:0]            rid_q;
	logic                   ok_q;
	logic                   last_q;

	ptt_ctl_t               ctl;
	ptt_entry_t             ent       [NUM_TIMERS];
	ptt_entry_t             ent_left  [NUM_TIMERS];
	ptt_entry_t             ent_right [NUM_TIMERS];
	logic [31:0]            dkey      [NUM_TIMERS];
	logic [31:0]            dkey_right[NUM_TIMERS];
	logic [NUM_TIMERS-1:0]  gt_vec;
	logic [NUM_TIMERS-1:0]  gt_left;
	logic [NUM_TIMERS-1:0]  match_vec;
	logic [NUM_TIMERS-1:0]  due_vec;
	logic [NUM_TIMERS-1:0]  due_right;
	logic [NUM_TIMERS-1:0]  valid_vec;

	logic        accept;
	logic        out_free;
	logic        found;
	logic        can_insert;
	logic        div_start;
	logic        div_done;
	logic [31:0] div_quo;
	logic [31:0] ms_clamped;
	logic        div_fire;
	logic        any_due;
	logic        rest_due;
	logic        scan_step;
	logic        emit;
	logic        emit_last;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE) || !out_free;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		for (int i = 0; i < NUM_TIMERS; i++) begin
			valid_vec[i] = ent[i].valid;
			if (i == 0) begin
				ent_left[i] = '0;
				gt_left[i]  = 1'b0;
			end else begin
				ent_left[i] = ent[i-1];
				gt_left[i]  = gt_vec[i-1];
			end
			if (i == NUM_TIMERS - 1) begin
				ent_right[i]  = '0;
				due_right[i]  = 1'b0;
				dkey_right[i] = '0;
			end else begin
				ent_right[i]  = ent[i+1];
				due_right[i]  = due_vec[i+1];
				dkey_right[i] = dkey[i+1];
			end
		end
	end

	assign found      = |match_vec;
	assign can_insert = !found && !valid_vec[NUM_TIMERS-1];

	assign ms_clamped = (period_ms < 32'(TICK_MS)) ? 32'(TICK_MS) : period_ms;
	assign div_start  = accept && (command == CMD_SET);
	assign div_fire   = (state_q == ST_DIV) && div_done && out_free;

	assign any_due   = |due_vec;
	assign rest_due  = |(due_vec >> 1);
	assign scan_step = (state_q == ST_SCAN) && any_due && out_free;
	assign emit      = scan_step && due_vec[0];
	assign emit_last = !rest_due || (n_q == RUN_CNT_W'(RESULT_LIMIT - 1));

	always_comb begin
		ctl.id    = (state_q == ST_IDLE) ? timer_id : id_q;
		ctl.ticks = div_quo;
		ctl.upd   = div_fire && found;
		ctl.ins   = div_fire && can_insert;
		ctl.del   = accept && (command == CMD_KILL) && found;
		ctl.tick  = accept && (command == CMD_TICK);
		ctl.shift = scan_step;
	end

	ptt_div #(
		.TICK_MS (TICK_MS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (ms_clamped),
		.done     (div_done),
		.quotient (div_quo)
	);

	for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
		ptt_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.left_ent  (ent_left[g]),
			.left_gt   (gt_left[g]),
			.right_ent (ent_right[g]),
			.right_due (due_right[g]),
			.right_key (dkey_right[g]),
			.ent       (ent[g]),
			.gt        (gt_vec[g]),
			.match     (match_vec[g]),
			.due       (due_vec[g]),
			.due_key   (dkey[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			n_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && command == CMD_SET) begin
						state_q <= ST_DIV;
					end else if (accept && command == CMD_TICK) begin
						state_q <= ST_SCAN;
						n_q     <= '0;
					end
				end
				ST_DIV: begin
					if (div_fire) begin
						state_q <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					if (!any_due || (emit && emit_last)) begin
						state_q <= ST_IDLE;
					end
					if (emit) begin
						n_q <= n_q + 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if ((accept && (command == CMD_KILL || command == CMD_QUERY)) || div_fire || emit) begin
				out_valid_q <= 1'b1;
			end else if (out_free) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			id_q <= timer_id;
		end
		if (accept && (command == CMD_KILL || command == CMD_QUERY)) begin
			kind_q <= (command == CMD_KILL) ? KIND_KILL : KIND_QUERY;
			rid_q  <= timer_id;
			ok_q   <= found;
			last_q <= 1'b1;
		end else if (div_fire) begin
			kind_q <= KIND_SET;
			rid_q  <= id_q;
			ok_q   <= found || can_insert;
			last_q <= 1'b1;
		end else if (emit) begin
			kind_q <= KIND_FIRED;
			rid_q  <= dkey[0];
			ok_q   <= 1'b1;
			last_q <= emit_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign reply_kind  = kind_q;
	assign reply_id    = rid_q;
	assign success     = ok_q;
	assign last_of_run = last_q;

	a_packed: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_vec & NUM_TIMERS'(valid_vec + 1'b1)) == '0)
		else $error("valid entries not packed at the head of the row");

	a_unique_id: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(match_vec))
		else $error("timer id held by more than one cell");

	a_ins_grows: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.ins |=> $countones(valid_vec) == $past($countones(valid_vec)) + 1)
		else $error("insert did not add exactly one entry");

	a_del_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.del |=> $countones(valid_vec) + 1 == $past($countones(valid_vec)))
		else $error("kill did not remove exactly one entry");

endmodule

`default_nettype wire
